FILE: src/vnt_pkg.sv
// Shared constants, types and tables for the value-noise terrain classifier.
package vnt_pkg;

    localparam int COORD_BITS = 11;
    localparam int OCTAVES    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int LEVEL_W    = 17;
    localparam int CLASS_W    = 3;
    localparam int CELL_BASE  = 48;
    localparam int FRAC_IDX_W = 6;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_SEED     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WATER    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BEACH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HILL     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MOUNTAIN = 3'd4;

    // Terrain class codes.
    localparam logic [CLASS_W-1:0] CLS_WATER    = 3'd0;
    localparam logic [CLASS_W-1:0] CLS_BEACH    = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_PLAIN    = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_HILL     = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_MOUNTAIN = 3'd4;

    // Reset values of the thresholds.
    localparam logic [LEVEL_W-1:0] WATER_RST    = 17'd22938;
    localparam logic [LEVEL_W-1:0] BEACH_RST    = 17'd26214;
    localparam logic [LEVEL_W-1:0] HILL_RST     = 17'd42598;
    localparam logic [LEVEL_W-1:0] MOUNTAIN_RST = 17'd52429;

    // Lattice hash constants.
    localparam logic [31:0] HASH_X    = 32'd374761393;
    localparam logic [31:0] HASH_Y    = 32'd668265263;
    localparam logic [31:0] HASH_S    = 32'd2246822519;
    localparam logic [31:0] HASH_MIX  = 32'd1274126177;
    localparam logic [31:0] SEED_STEP = 32'd101;

    // Division by three for values of up to 16 bits: (n * DIV3_MUL) >> DIV3_SH.
    localparam logic [15:0] DIV3_MUL = 16'd43691;
    localparam int          DIV3_SH  = 17;

    // Stretch: subtract the offset, then divide by 75 through a reciprocal.
    localparam logic [23:0] STRETCH_OFS = 24'd2949120;
    localparam logic [24:0] DIV75_MUL   = 25'd28633116;
    localparam int          DIV75_SH    = 31;
    localparam logic [LEVEL_W-1:0] LEVEL_ONE = 17'd65536;

    typedef logic [15:0] t_ease_tab [CELL_BASE];

    // Smoothstep of the fraction r/48 in Q0.16, for r = 0..47.
    function automatic t_ease_tab ease_init();
        t_ease_tab      tab;
        longint unsigned f;
        longint unsigned p;
        for (int i = 0; i < CELL_BASE; i++) begin
            f = (longint'(i) << 16) / CELL_BASE;
            p = f * f * (64'd196608 - 64'd2 * f);
            tab[i] = p[47:32];
        end
        return tab;
    endfunction

    localparam t_ease_tab EASE_TAB = ease_init();

endpackage

FILE: src/vnt_in_if.sv
// Request channel carrying one map coordinate.
interface vnt_in_if;
    logic                            valid;
    logic                            ready;
    logic [vnt_pkg::COORD_BITS-1:0] coord_x;
    logic [vnt_pkg::COORD_BITS-1:0] coord_y;

    modport source (output valid, coord_x, coord_y, input ready);
    modport sink   (input valid, coord_x, coord_y, output ready);
endinterface

FILE: src/vnt_out_if.sv
// Result channel carrying height and terrain class.
interface vnt_out_if;
    logic                         valid;
    logic                         ready;
    logic [vnt_pkg::CLASS_W-1:0]  terrain_class;
    logic [vnt_pkg::LEVEL_W-1:0]  height_level;

    modport source (output valid, terrain_class, height_level, input ready);
    modport sink   (input valid, terrain_class, height_level, output ready);
endinterface

FILE: src/value_noise_terrain_classifier.sv
// A request accepted into the stage-1 registers passes through stages 2 to 8 before its result
// is loaded into the output register.
// Throughput: one request per cycle; the nine-stage pipeline moves as a whole and
// holds when its output register is full and not taken.
// Reset clears all valid bits and loads the documented threshold and seed values.
// The pipeline depth is set by the hash multiplies and the two blend multiplies.
module value_noise_terrain_classifier (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [vnt_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [vnt_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    vnt_in_if.sink                            i_req,
    vnt_out_if.source                         o_rsp
);
    localparam int CW = vnt_pkg::COORD_BITS;
    localparam int NO = vnt_pkg::OCTAVES;
    localparam int FW = vnt_pkg::FRAC_IDX_W;
    localparam int LW = vnt_pkg::LEVEL_W;

    // Configuration registers.
    logic [31:0]   r_seed;
    logic [LW-1:0] r_water, r_beach, r_hill, r_mountain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed     <= '0;
            r_water    <= vnt_pkg::WATER_RST;
            r_beach    <= vnt_pkg::BEACH_RST;
            r_hill     <= vnt_pkg::HILL_RST;
            r_mountain <= vnt_pkg::MOUNTAIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vnt_pkg::REG_SEED:     r_seed     <= i_cfg_data;
                vnt_pkg::REG_WATER:    r_water    <= i_cfg_data[LW-1:0];
                vnt_pkg::REG_BEACH:    r_beach    <= i_cfg_data[LW-1:0];
                vnt_pkg::REG_HILL:     r_hill     <= i_cfg_data[LW-1:0];
                vnt_pkg::REG_MOUNTAIN: r_mountain <= i_cfg_data[LW-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline control: all stages advance together when the output can move.
    logic       ce;
    logic [8:1] r_v;
    logic       r_ov;

    assign ce          = !r_ov || o_rsp.ready;
    assign i_req.ready = ce;
    assign o_rsp.valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (ce) begin
            r_v  <= {r_v[7:1], i_req.valid};
            r_ov <= r_v[8];
        end
    end

    // Stage 1: per octave, cell index by a reciprocal divide by three, and seed product.
    logic [CW-1:0] r1_x, r1_y;
    logic [CW-1:0] r1_qx [NO];
    logic [CW-1:0] r1_qy [NO];
    logic [31:0]   r1_sp [NO];

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r1_x <= i_req.coord_x;
            r1_y <= i_req.coord_y;
            for (int o = 0; o < NO; o++) begin
                r1_qx[o] <= CW'(((32'(i_req.coord_x) >> (4 - o)) * 32'(vnt_pkg::DIV3_MUL))
                                >> vnt_pkg::DIV3_SH);
                r1_qy[o] <= CW'(((32'(i_req.coord_y) >> (4 - o)) * 32'(vnt_pkg::DIV3_MUL))
                                >> vnt_pkg::DIV3_SH);
                r1_sp[o] <= (r_seed + 32'(o) * vnt_pkg::SEED_STEP) * vnt_pkg::HASH_S;
            end
        end
    end

    // Stage 2: remainder, smoothstep lookup and coordinate hash products.
    logic [15:0] r2_sx [NO];
    logic [15:0] r2_sy [NO];
    logic [31:0] r2_px [NO];
    logic [31:0] r2_py [NO];
    logic [31:0] r2_sp [NO];
    logic [FW-1:0] rx [NO];
    logic [FW-1:0] ry [NO];

    always_comb begin
        for (int o = 0; o < NO; o++) begin
            rx[o] = FW'(r1_x - CW'((r1_qx[o] * CW'(3)) << (4 - o)));
            ry[o] = FW'(r1_y - CW'((r1_qy[o] * CW'(3)) << (4 - o)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int o = 0; o < NO; o++) begin
                r2_sx[o] <= vnt_pkg::EASE_TAB[FW'(rx[o] << o)];
                r2_sy[o] <= vnt_pkg::EASE_TAB[FW'(ry[o] << o)];
                r2_px[o] <= 32'(r1_qx[o]) * vnt_pkg::HASH_X;
                r2_py[o] <= 32'(r1_qy[o]) * vnt_pkg::HASH_Y;
                r2_sp[o] <= r1_sp[o];
            end
        end
    end

    // Stage 3: hash sums of the four corners and the first xor-shift.
    logic [31:0] r3_h [NO][4];
    logic [15:0] r3_sx [NO];
    logic [15:0] r3_sy [NO];
    logic [31:0] hs [NO][4];

    always_comb begin
        for (int o = 0; o < NO; o++) begin
            for (int k = 0; k < 4; k++) begin
                hs[o][k] = r2_px[o] + (k[0] ? vnt_pkg::HASH_X : 32'd0)
                         + r2_py[o] + (k[1] ? vnt_pkg::HASH_Y : 32'd0) + r2_sp[o];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int o = 0; o < NO; o++) begin
                for (int k = 0; k < 4; k++) begin
                    r3_h[o][k] <= hs[o][k] ^ (hs[o][k] >> 13);
                end
                r3_sx[o] <= r2_sx[o];
                r3_sy[o] <= r2_sy[o];
            end
        end
    end

    // Stage 4: hash mixing multiply.
    logic [31:0] r4_h [NO][4];
    logic [15:0] r4_sx [NO];
    logic [15:0] r4_sy [NO];

    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int o = 0; o < NO; o++) begin
                for (int k = 0; k < 4; k++) begin
                    r4_h[o][k] <= r3_h[o][k] * vnt_pkg::HASH_MIX;
                end
                r4_sx[o] <= r3_sx[o];
                r4_sy[o] <= r3_sy[o];
            end
        end
    end

    // Stage 5: final xor-shift to corner values, then blend along x.
    logic [15:0] cv [NO][4];
    logic signed [16:0] dx0 [NO];
    logic signed [16:0] dx1 [NO];
    logic signed [34:0] mx0 [NO];
    logic signed [34:0] mx1 [NO];
    logic [15:0] r5_a [NO];
    logic [15:0] r5_b [NO];
    logic [15:0] r5_sy [NO];

    always_comb begin
        for (int o = 0; o < NO; o++) begin
            for (int k = 0; k < 4; k++) begin
                cv[o][k] = r4_h[o][k][15:0] ^ r4_h[o][k][31:16];
            end
            dx0[o] = $signed({1'b0, cv[o][1]}) - $signed({1'b0, cv[o][0]});
            dx1[o] = $signed({1'b0, cv[o][3]}) - $signed({1'b0, cv[o][2]});
            mx0[o] = 35'(dx0[o]) * 35'($signed({1'b0, r4_sx[o]}));
            mx1[o] = 35'(dx1[o]) * 35'($signed({1'b0, r4_sx[o]}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int o = 0; o < NO; o++) begin
                r5_a[o]  <= cv[o][0] + mx0[o][31:16];
                r5_b[o]  <= cv[o][2] + mx1[o][31:16];
                r5_sy[o] <= r4_sy[o];
            end
        end
    end

    // Stage 6: blend along y to the octave value.
    logic signed [16:0] dy [NO];
    logic signed [34:0] my [NO];
    logic [15:0] r6_n [NO];

    always_comb begin
        for (int o = 0; o < NO; o++) begin
            dy[o] = $signed({1'b0, r5_b[o]}) - $signed({1'b0, r5_a[o]});
            my[o] = 35'(dy[o]) * 35'($signed({1'b0, r5_sy[o]}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int o = 0; o < NO; o++) begin
                r6_n[o] <= r5_a[o] + my[o][31:16];
            end
        end
    end

    // Stage 7: weighted octave sum, times eleven, minus the stretch offset.
    logic [19:0] acc;
    logic [23:0] num;
    logic [23:0] r7_d;
    logic        r7_neg;

    always_comb begin
        acc = (20'(r6_n[0]) << 3) + (20'(r6_n[1]) << 2) + (20'(r6_n[2]) << 1)
            + 20'(r6_n[3]);
        num = (24'(acc) << 3) + (24'(acc) << 1) + 24'(acc);
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r7_neg <= (num <= vnt_pkg::STRETCH_OFS);
            r7_d   <= num - vnt_pkg::STRETCH_OFS;
        end
    end

    // Stage 8: divide by 75 through the reciprocal multiply.
    logic [48:0] r8_p;
    logic        r8_neg;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r8_p   <= 49'(r7_d) * 49'(vnt_pkg::DIV75_MUL);
            r8_neg <= r7_neg;
        end
    end

    // Stage 9: clamp and classify into the output register.
    logic [17:0]         q;
    logic [LW-1:0]       hgt;
    logic [vnt_pkg::CLASS_W-1:0] cls;
    logic [vnt_pkg::CLASS_W-1:0] r_cls;
    logic [LW-1:0]       r_hgt;

    always_comb begin
        q = r8_p[vnt_pkg::DIV75_SH +: 18];
        if (r8_neg) begin
            hgt = '0;
        end else if (q > 18'(vnt_pkg::LEVEL_ONE)) begin
            hgt = vnt_pkg::LEVEL_ONE;
        end else begin
            hgt = q[LW-1:0];
        end
        if (hgt < r_water) begin
            cls = vnt_pkg::CLS_WATER;
        end else if (hgt < r_beach) begin
            cls = vnt_pkg::CLS_BEACH;
        end else if (hgt < r_hill) begin
            cls = vnt_pkg::CLS_PLAIN;
        end else if (hgt < r_mountain) begin
            cls = vnt_pkg::CLS_HILL;
        end else begin
            cls = vnt_pkg::CLS_MOUNTAIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_cls <= cls;
            r_hgt <= hgt;
        end
    end

    assign o_rsp.terrain_class = r_cls;
    assign o_rsp.height_level  = r_hgt;

endmodule
